@@ rtl/gsg_pkg.sv @@
`default_nettype none
package gsg_pkg;

    localparam int GRID_SIZE = 64;
    localparam int CELLS     = GRID_SIZE * GRID_SIZE;
    localparam int COORD_W   = $clog2(GRID_SIZE);
    localparam int CELL_W    = $clog2(CELLS);
    localparam int ADDR_W    = $clog2(2 * CELLS);
    localparam int VAL_W     = 16;
    localparam int IDX_W     = 12;
    localparam int OP_W      = 2;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int ONE_Q15   = 32768;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DIFF_U = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_V = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FEED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KILL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DT     = 3'd4;

    // read address selects
    localparam logic [2:0] SEL_C    = 3'd0;
    localparam logic [2:0] SEL_L    = 3'd1;
    localparam logic [2:0] SEL_R    = 3'd2;
    localparam logic [2:0] SEL_U    = 3'd3;
    localparam logic [2:0] SEL_D    = 3'd4;
    localparam logic [2:0] SEL_ITEM = 3'd5;

    typedef struct packed {
        logic [CFG_W-1:0] diff_u;
        logic [CFG_W-1:0] diff_v;
        logic [CFG_W-1:0] feed;
        logic [CFG_W-1:0] kill;
        logic [CFG_W-1:0] dt;
    } gsg_cfg_t;

    typedef struct packed {
        logic       latch_item;
        logic       rd_en;
        logic [2:0] rd_sel;
        logic       wr_item;
        logic       wr_cell;
        logic       load_out;
    } gsg_cmd_t;

    typedef struct packed {
        logic last_cell;
    } gsg_stat_t;

    typedef struct packed {
        logic [VAL_W-1:0] u;
        logic [VAL_W-1:0] v;
        logic [OP_W-1:0]  op;
    } gsg_res_t;

endpackage
`default_nettype wire

@@ rtl/gsg_ctrl.sv @@
`default_nettype none
module gsg_ctrl
    import gsg_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic [OP_W-1:0] opcode,
    input  wire logic            out_free,
    input  wire gsg_stat_t       stat,
    output gsg_cmd_t             cmd,
    output logic                 busy
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_WRC  = 4'd1;
    localparam logic [3:0] ST_RDI  = 4'd2;
    localparam logic [3:0] ST_RC   = 4'd3;
    localparam logic [3:0] ST_RL   = 4'd4;
    localparam logic [3:0] ST_RR   = 4'd5;
    localparam logic [3:0] ST_RU   = 4'd6;
    localparam logic [3:0] ST_RD   = 4'd7;
    localparam logic [3:0] ST_CAP  = 4'd8;
    localparam logic [3:0] ST_S1   = 4'd9;
    localparam logic [3:0] ST_S2   = 4'd10;
    localparam logic [3:0] ST_S3   = 4'd11;
    localparam logic [3:0] ST_S4   = 4'd12;
    localparam logic [3:0] ST_WR   = 4'd13;
    localparam logic [3:0] ST_FIN  = 4'd14;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = SEL_ITEM;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (in_valid)
                begin
                    cmd.latch_item = 1'b1;
                    case (opcode)
                        OP_WRITE: state_next = ST_WRC;
                        OP_READ:  state_next = ST_RDI;
                        OP_STEP:  state_next = ST_RC;
                        default:  state_next = ST_FIN;
                    endcase
                end
            end
            ST_WRC:
            begin
                cmd.wr_item = 1'b1;
                state_next  = ST_FIN;
            end
            ST_RDI:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_FIN;
            end
            ST_RC:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_C;
                state_next = ST_RL;
            end
            ST_RL:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_L;
                state_next = ST_RR;
            end
            ST_RR:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_R;
                state_next = ST_RU;
            end
            ST_RU:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_U;
                state_next = ST_RD;
            end
            ST_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_D;
                state_next = ST_CAP;
            end
            ST_CAP: state_next = ST_S1;
            ST_S1:  state_next = ST_S2;
            ST_S2:  state_next = ST_S3;
            ST_S3:  state_next = ST_S4;
            ST_S4:  state_next = ST_WR;
            ST_WR:
            begin
                cmd.wr_cell = 1'b1;
                state_next  = stat.last_cell ? ST_FIN : ST_RC;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/gsg_datapath.sv @@
`default_nettype none
module gsg_datapath
    import gsg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gsg_cmd_t          cmd,
    input  wire gsg_cfg_t          cfg,
    input  wire logic [OP_W-1:0]   opcode,
    input  wire logic [IDX_W-1:0]  cell_index,
    input  wire logic [VAL_W-1:0]  u_in,
    input  wire logic [VAL_W-1:0]  v_in,
    output gsg_stat_t              stat,
    output gsg_res_t               res
);

    localparam logic [CELL_W-1:0] LAST_C  = CELL_W'(CELLS - 1);
    localparam logic [CELL_W-1:0] G_M1    = CELL_W'(GRID_SIZE - 1);
    localparam logic [CELL_W-1:0] G_C     = CELL_W'(GRID_SIZE);
    localparam logic [CELL_W-1:0] WRAP_Y  = CELL_W'(CELLS - GRID_SIZE);
    localparam logic [COORD_W-1:0] MAX_XY = COORD_W'(GRID_SIZE - 1);
    localparam logic [VAL_W-1:0]  ONE     = VAL_W'(ONE_Q15);

    // {u, v} per entry, bank in the upper half
    logic [2*VAL_W-1:0] mem [2*CELLS];
    logic [2*VAL_W-1:0] mem_q_reg;

    logic               bank_reg;
    logic [CELL_W-1:0]  c_reg;
    logic [COORD_W-1:0] x_reg, y_reg;
    logic [OP_W-1:0]    op_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [VAL_W-1:0]   ui_reg, vi_reg;
    logic               cap_reg;
    logic [2:0]         cap_sel_reg;

    logic [VAL_W-1:0] nc_u_reg, nc_v_reg, nl_u_reg, nl_v_reg, nr_u_reg, nr_v_reg;
    logic [VAL_W-1:0] nu_u_reg, nu_v_reg, nd_u_reg, nd_v_reg;

    logic               idx_ok;
    logic [CELL_W-1:0]  nb_cell, n_l, n_r, n_u, n_d;
    logic [ADDR_W-1:0]  rd_addr, wr_addr, cur_off, oth_off;
    logic               wr_en;
    logic [2*VAL_W-1:0] wr_data;

    assign idx_ok  = (IDX_W + 1)'(idx_reg) < (IDX_W + 1)'(CELLS);
    assign cur_off = bank_reg ? ADDR_W'(CELLS) : '0;
    assign oth_off = bank_reg ? '0 : ADDR_W'(CELLS);

    // toroidal neighbors
    assign n_l = (x_reg == '0)     ? CELL_W'(c_reg + G_M1) : CELL_W'(c_reg - 1'b1);
    assign n_r = (x_reg == MAX_XY) ? CELL_W'(c_reg - G_M1) : CELL_W'(c_reg + 1'b1);
    assign n_u = (y_reg == '0)     ? CELL_W'(c_reg + WRAP_Y) : CELL_W'(c_reg - G_C);
    assign n_d = (y_reg == MAX_XY) ? CELL_W'(c_reg - WRAP_Y) : CELL_W'(c_reg + G_C);

    always_comb
    begin
        case (cmd.rd_sel)
            SEL_C:   nb_cell = c_reg;
            SEL_L:   nb_cell = n_l;
            SEL_R:   nb_cell = n_r;
            SEL_U:   nb_cell = n_u;
            SEL_D:   nb_cell = n_d;
            default: nb_cell = CELL_W'(idx_reg);
        endcase
    end

    assign rd_addr = ADDR_W'(nb_cell) + cur_off;
    assign stat.last_cell = (c_reg == LAST_C);

    // ---- arithmetic stages ----
    logic signed [18:0] lapu_reg, lapv_reg;
    logic [31:0]        uv_reg;
    logic signed [35:0] fu_reg;
    logic [33:0]        fkv_reg;
    logic [VAL_W-1:0]   u1_reg, v1_reg, u2_reg, v2_reg, u3_reg, v3_reg, u4_reg, v4_reg;
    logic signed [35:0] dul_reg, dvl_reg, fu2_reg;
    logic [47:0]        uvv_reg;
    logic [33:0]        fkv2_reg;
    logic signed [37:0] du_reg, dv_reg;
    logic signed [55:0] pu_reg, pv_reg;

    logic [18:0]        sum_u, sum_v;
    logic signed [17:0] one_m_u;
    logic [47:0]        react;
    logic signed [55:0] acc_u, acc_v;
    logic signed [25:0] r_u, r_v;
    logic [VAL_W-1:0]   cl_u, cl_v;

    assign sum_u   = 19'(nl_u_reg) + 19'(nr_u_reg) + 19'(nu_u_reg) + 19'(nd_u_reg);
    assign sum_v   = 19'(nl_v_reg) + 19'(nr_v_reg) + 19'(nu_v_reg) + 19'(nd_v_reg);
    assign one_m_u = $signed(18'(ONE_Q15)) - $signed({2'b00, nc_u_reg});
    assign react   = (uvv_reg + 48'(1 << 13)) >> 14;
    assign acc_u   = $signed({10'd0, u4_reg, 30'd0}) + pu_reg + 56'sd536870912;
    assign acc_v   = $signed({10'd0, v4_reg, 30'd0}) + pv_reg + 56'sd536870912;
    assign r_u     = 26'(acc_u >>> 30);
    assign r_v     = 26'(acc_v >>> 30);

    always_comb
    begin
        if (r_u < 0)                       cl_u = '0;
        else if (r_u > 26'sd32768)         cl_u = ONE;
        else                               cl_u = r_u[VAL_W-1:0];
        if (r_v < 0)                       cl_v = '0;
        else if (r_v > 26'sd32768)         cl_v = ONE;
        else                               cl_v = r_v[VAL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        // stage 1: laplacians, u*v, feed and decay terms
        lapu_reg <= $signed(sum_u) - $signed({1'b0, nc_u_reg, 2'b00});
        lapv_reg <= $signed(sum_v) - $signed({1'b0, nc_v_reg, 2'b00});
        uv_reg   <= 32'(nc_u_reg) * 32'(nc_v_reg);
        fu_reg   <= 36'($signed({1'b0, cfg.feed}) * one_m_u);
        fkv_reg  <= 34'((17'(cfg.feed) + 17'(cfg.kill)) * 34'(nc_v_reg));
        u1_reg   <= nc_u_reg;
        v1_reg   <= nc_v_reg;
        // stage 2: diffusion products, u*v*v
        dul_reg  <= 36'($signed({1'b0, cfg.diff_u}) * lapu_reg);
        dvl_reg  <= 36'($signed({1'b0, cfg.diff_v}) * lapv_reg);
        uvv_reg  <= 48'(uv_reg) * 48'(v1_reg);
        fu2_reg  <= fu_reg;
        fkv2_reg <= fkv_reg;
        u2_reg   <= u1_reg;
        v2_reg   <= v1_reg;
        // stage 3: derivatives, Q.31
        du_reg   <= 38'(dul_reg) - $signed({4'd0, react[33:0]}) + 38'(fu2_reg);
        dv_reg   <= 38'(dvl_reg) + $signed({4'd0, react[33:0]})
                    - $signed({4'd0, fkv2_reg});
        u3_reg   <= u2_reg;
        v3_reg   <= v2_reg;
        // stage 4: scale by dt
        pu_reg   <= 56'($signed({1'b0, cfg.dt}) * du_reg);
        pv_reg   <= 56'($signed({1'b0, cfg.dt}) * dv_reg);
        u4_reg   <= u3_reg;
        v4_reg   <= v3_reg;
    end

    assign wr_en   = cmd.wr_cell || (cmd.wr_item && idx_ok);
    assign wr_addr = cmd.wr_cell ? ADDR_W'(c_reg) + oth_off
                                 : ADDR_W'(CELL_W'(idx_reg)) + cur_off;
    assign wr_data = cmd.wr_cell ? {cl_u, cl_v} : {ui_reg, vi_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            op_reg  <= opcode;
            idx_reg <= cell_index;
            ui_reg  <= (u_in > ONE) ? ONE : u_in;
            vi_reg  <= (v_in > ONE) ? ONE : v_in;
        end
        if (cap_reg)
        begin
            case (cap_sel_reg)
                SEL_C:   {nc_u_reg, nc_v_reg} <= mem_q_reg;
                SEL_L:   {nl_u_reg, nl_v_reg} <= mem_q_reg;
                SEL_R:   {nr_u_reg, nr_v_reg} <= mem_q_reg;
                SEL_U:   {nu_u_reg, nu_v_reg} <= mem_q_reg;
                SEL_D:   {nd_u_reg, nd_v_reg} <= mem_q_reg;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg    <= 1'b0;
            c_reg       <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            cap_reg     <= 1'b0;
            cap_sel_reg <= SEL_ITEM;
        end
        else
        begin
            cap_reg     <= cmd.rd_en;
            cap_sel_reg <= cmd.rd_sel;
            if (cmd.latch_item)
            begin
                c_reg <= '0;
                x_reg <= '0;
                y_reg <= '0;
            end
            else if (cmd.wr_cell)
            begin
                c_reg <= CELL_W'(c_reg + 1'b1);
                if (x_reg == MAX_XY)
                begin
                    x_reg <= '0;
                    y_reg <= COORD_W'(y_reg + 1'b1);
                end
                else
                begin
                    x_reg <= COORD_W'(x_reg + 1'b1);
                end
                if (stat.last_cell)
                begin
                    bank_reg <= ~bank_reg;
                end
            end
        end
    end

    assign res.op = op_reg;
    assign res.u  = (op_reg == OP_READ && idx_ok) ? mem_q_reg[2*VAL_W-1:VAL_W] : '0;
    assign res.v  = (op_reg == OP_READ && idx_ok) ? mem_q_reg[VAL_W-1:0] : '0;

endmodule
`default_nettype wire

@@ rtl/gray_scott_grid_step.sv @@
// Gray-Scott reaction-diffusion engine on a 64x64 toroidal grid.
//
// Input channel (in_valid / in_stall): one beat carries opcode, cell_index,
// u_in, v_in. Opcodes: write a cell, read a cell, run one Euler substep
// over the whole grid, or a no-op. Output channel (out_valid / out_stall):
// exactly one beat per input beat, u_out/v_out hold the cell on a read and
// zero otherwise, op_done echoes the opcode.
//
// A write or read is done in a work state, then its output beat is loaded;
// a substep visits every cell in turn. The cell rate is set by the single
// memory read port fetching center and four neighbors, plus the four-stage
// multiply pipeline which is not overlapped across cells. One item is in
// work at a time; in_stall is low only when idle.
//
// The output beat sits in a register: a stalled receiver holds it while the
// next item is accepted and worked; it only waits at the end for the slot.
// Reset clears control and loads default coefficients; grid memory is not
// cleared, cells read before being written return undefined data. Config:
// cfg_we writes cfg_data to register cfg_index only while idle: user rule.
`default_nettype none
module gray_scott_grid_step
    import gsg_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [OP_W-1:0]      opcode,
    input  wire logic [IDX_W-1:0]     cell_index,
    input  wire logic [VAL_W-1:0]     u_in,
    input  wire logic [VAL_W-1:0]     v_in,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [VAL_W-1:0]          u_out,
    output logic [VAL_W-1:0]          v_out,
    output logic [OP_W-1:0]           op_done
);

    gsg_cfg_t  cfg_reg;
    gsg_cmd_t  cmd;
    gsg_stat_t stat;
    gsg_res_t  res;
    logic      busy;
    logic      out_free;
    logic      out_valid_reg, out_valid_next;
    gsg_res_t  out_reg;

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.diff_u <= 16'd10486;
            cfg_reg.diff_v <= 16'd5243;
            cfg_reg.feed   <= 16'd1966;
            cfg_reg.kill   <= 16'd4063;
            cfg_reg.dt     <= 16'd16384;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DIFF_U: cfg_reg.diff_u <= cfg_data;
                REG_DIFF_V: cfg_reg.diff_v <= cfg_data;
                REG_FEED:   cfg_reg.feed   <= cfg_data;
                REG_KILL:   cfg_reg.kill   <= cfg_data;
                REG_DT:     cfg_reg.dt     <= cfg_data;
                default: ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = busy;

    gsg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    gsg_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg        (cfg_reg),
        .opcode     (opcode),
        .cell_index (cell_index),
        .u_in       (u_in),
        .v_in       (v_in),
        .stat       (stat),
        .res        (res)
    );

    // output beat register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign u_out     = out_reg.u;
    assign v_out     = out_reg.v;
    assign op_done   = out_reg.op;

    // an accepted item always makes the block busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("accepted item did not start work");

    // grid cells are never written back while idle
    a_idle_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !cmd.wr_cell && !cmd.wr_item)
        else $error("memory write while idle");

    // a loaded result is presented on the next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid)
        else $error("result beat lost");

endmodule
`default_nettype wire

@@ bench/tb.sv @@
`default_nettype none
module tb
    import gsg_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // opcode 3 is a no-op with no package constant
    localparam logic [OP_W-1:0] OP_NOP = 2'd3;

    typedef struct {
        logic [VAL_W-1:0] u;
        logic [VAL_W-1:0] v;
        logic [OP_W-1:0]  op;
    } grid_beat_t;

    // Shadow of the grid banks and coefficients; predicts one output beat
    // per accepted input beat and matches beats in order.
    class grid_tracker;
        logic [VAL_W-1:0] u_mem [2*CELLS];
        logic [VAL_W-1:0] v_mem [2*CELLS];
        bit               bank;
        logic [CFG_W-1:0] coef [5];
        grid_beat_t       expected_beats [$];
        int               errors;

        function new();
            bank = 0;
            errors = 0;
            coef[REG_DIFF_U] = 16'd10486;
            coef[REG_DIFF_V] = 16'd5243;
            coef[REG_FEED]   = 16'd1966;
            coef[REG_KILL]   = 16'd4063;
            coef[REG_DT]     = 16'd16384;
            foreach (u_mem[i])
            begin
                u_mem[i] = '0;
                v_mem[i] = '0;
            end
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        // floor(x / 2^s + 1/2)
        function longint rnd_shift(longint x, int s);
            return (x + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function logic [VAL_W-1:0] clamp_unit(longint x);
            if (x < 0) return '0;
            if (x > ONE_Q15) return VAL_W'(ONE_Q15);
            return VAL_W'(x);
        endfunction

        function void euler_substep();
            int     cb, nb, xm, xp, ym, yp, c;
            longint uu, vv, lap_u, lap_v, react, du, dv;
            longint kdu, kdv, kf, kfk, kdt;
            cb  = bank ? CELLS : 0;
            nb  = bank ? 0 : CELLS;
            kdu = longint'(coef[REG_DIFF_U]);
            kdv = longint'(coef[REG_DIFF_V]);
            kf  = longint'(coef[REG_FEED]);
            kfk = kf + longint'(coef[REG_KILL]);
            kdt = longint'(coef[REG_DT]);
            for (int y = 0; y < GRID_SIZE; y++)
            begin
                ym = (y == 0) ? GRID_SIZE - 1 : y - 1;
                yp = (y == GRID_SIZE - 1) ? 0 : y + 1;
                for (int x = 0; x < GRID_SIZE; x++)
                begin
                    xm = (x == 0) ? GRID_SIZE - 1 : x - 1;
                    xp = (x == GRID_SIZE - 1) ? 0 : x + 1;
                    c  = y * GRID_SIZE + x;
                    uu = longint'(u_mem[cb + c]);
                    vv = longint'(v_mem[cb + c]);
                    lap_u = longint'(u_mem[cb + y*GRID_SIZE + xm])
                          + longint'(u_mem[cb + y*GRID_SIZE + xp])
                          + longint'(u_mem[cb + ym*GRID_SIZE + x])
                          + longint'(u_mem[cb + yp*GRID_SIZE + x]) - 4 * uu;
                    lap_v = longint'(v_mem[cb + y*GRID_SIZE + xm])
                          + longint'(v_mem[cb + y*GRID_SIZE + xp])
                          + longint'(v_mem[cb + ym*GRID_SIZE + x])
                          + longint'(v_mem[cb + yp*GRID_SIZE + x]) - 4 * vv;
                    react = rnd_shift(uu * vv * vv, 14);
                    du = kdu * lap_u - react + kf * (ONE_Q15 - uu);
                    dv = kdv * lap_v + react - kfk * vv;
                    u_mem[nb + c] = clamp_unit(rnd_shift(uu * (64'sd1 <<< 30) + kdt * du, 30));
                    v_mem[nb + c] = clamp_unit(rnd_shift(vv * (64'sd1 <<< 30) + kdt * dv, 30));
                end
            end
            bank = !bank;
        endfunction

        function void predict_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                   logic [VAL_W-1:0] ui, logic [VAL_W-1:0] vi);
            grid_beat_t b;
            int         a;
            a = (bank ? CELLS : 0) + int'(idx);
            if (ui > ONE_Q15) ui = VAL_W'(ONE_Q15);
            if (vi > ONE_Q15) vi = VAL_W'(ONE_Q15);
            b.u = '0;
            b.v = '0;
            b.op = op;
            if (op == OP_WRITE)
            begin
                u_mem[a] = ui;
                v_mem[a] = vi;
            end
            else if (op == OP_READ)
            begin
                b.u = u_mem[a];
                b.v = v_mem[a];
            end
            else if (op == OP_STEP)
            begin
                euler_substep();
            end
            expected_beats.push_back(b);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
            errors++;
        endtask

        task match_beat(logic [VAL_W-1:0] u, logic [VAL_W-1:0] v, logic [OP_W-1:0] op);
            grid_beat_t b;
            if (expected_beats.size() == 0)
            begin
                report("beat with nothing pending, op", int'(op), -1);
                return;
            end
            b = expected_beats.pop_front();
            if (op !== b.op) report("op_done", int'(op), int'(b.op));
            if (u !== b.u) report("u_out", int'(u), int'(b.u));
            if (v !== b.v) report("v_out", int'(v), int'(b.v));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [OP_W-1:0]      opcode = '0;
    logic [IDX_W-1:0]     cell_index = '0;
    logic [VAL_W-1:0]     u_in = '0;
    logic [VAL_W-1:0]     v_in = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [VAL_W-1:0]     u_out;
    logic [VAL_W-1:0]     v_out;
    logic [OP_W-1:0]      op_done;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    grid_tracker tracker = new();

    gray_scott_grid_step u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .cell_index (cell_index),
        .u_in       (u_in),
        .v_in       (v_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .u_out      (u_out),
        .v_out      (v_out),
        .op_done    (op_done)
    );

    always #4 clk = ~clk;

    // receiver: random stall, output beat checked when taken
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.match_beat(u_out, v_out, op_done);
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // hard stop; eight substeps plus the preload fit well inside this
    initial
    begin
        #40ms;
        $display("== FAIL ==");
        $finish;
    end

    // one input beat; in_valid stays high after accept so back-to-back
    // beats never lower and raise it in one step
    task automatic send_beat(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                             logic [VAL_W-1:0] ui, logic [VAL_W-1:0] vi);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        cell_index <= idx;
        u_in       <= ui;
        v_in       <= vi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.predict_item(op, idx, ui, vi);
    endtask

    // sender holds off until every beat is back, then a few idle cycles
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic load_coefs(logic [CFG_W-1:0] du, logic [CFG_W-1:0] dv,
                              logic [CFG_W-1:0] f, logic [CFG_W-1:0] k,
                              logic [CFG_W-1:0] dt);
        logic [CFG_W-1:0] vals [5];
        vals = '{du, dv, f, k, dt};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            tracker.coef[i] = vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [VAL_W-1:0] rand_val();
        // mostly legal Q1.15, sometimes any 16 bits to exercise saturation
        if ($urandom_range(99) < 25)
            return VAL_W'($urandom);
        return VAL_W'($urandom_range(ONE_Q15, 0));
    endfunction

    // random mix of write/read/no-op with the requested number of substeps spread in
    task automatic random_phase(int count, int steps);
        int r;
        int gap;
        gap = count / (steps + 1);
        for (int i = 0; i < count; i++)
        begin
            if (steps > 0 && i > 0 && (i % gap) == 0 && i / gap <= steps)
                send_beat(OP_STEP, IDX_W'($urandom), rand_val(), rand_val());
            r = $urandom_range(99);
            if (r < 45)
                send_beat(OP_WRITE, IDX_W'($urandom), rand_val(), rand_val());
            else if (r < 88)
                send_beat(OP_READ, IDX_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
            else
                send_beat(OP_NOP, IDX_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 27;
        recv_idle_pct = 58;
        load_coefs(16'd10486, 16'd5243, 16'd1966, 16'd4063, 16'd16384);

        // preload every cell so no substep or read touches unwritten memory
        for (int c = 0; c < CELLS; c++)
            send_beat(OP_WRITE, IDX_W'(c), rand_val(), rand_val());

        // directed: value extremes, saturation above one, corners, no-op, step
        send_beat(OP_WRITE, 12'd0,    16'd0,     16'd32768);
        send_beat(OP_WRITE, 12'd4095, 16'hFFFF,  16'd32769);
        send_beat(OP_WRITE, 12'd1,    16'd32768, 16'd0);
        send_beat(OP_WRITE, 12'd2048, 16'h8001,  16'h7FFF);
        send_beat(OP_READ,  12'd0,    16'hFFFF,  16'hFFFF);
        send_beat(OP_READ,  12'd4095, 16'd0,     16'd0);
        send_beat(OP_READ,  12'd1,    16'd0,     16'd0);
        send_beat(OP_READ,  12'd2048, 16'd0,     16'd0);
        send_beat(OP_NOP,   12'hFFF,  16'hFFFF,  16'hFFFF);
        send_beat(OP_NOP,   12'd0,    16'd0,     16'd0);
        send_beat(OP_STEP,  12'd0,    16'd0,     16'd0);
        send_beat(OP_READ,  12'd0,    16'd0,     16'd0);
        send_beat(OP_READ,  12'd4095, 16'd0,     16'd0);
        send_beat(OP_READ,  12'd63,   16'd0,     16'd0);
        send_beat(OP_READ,  12'd4032, 16'd0,     16'd0);
        drain();

        // coefficient maxima: clamps both ends hard
        load_coefs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd32768);
        random_phase(35, 2);
        drain();

        send_idle_pct = 58;
        recv_idle_pct = 27;
        load_coefs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        random_phase(35, 2);
        drain();

        load_coefs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                   CFG_W'($urandom), CFG_W'($urandom_range(32768, 0)));
        random_phase(35, 2);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_coefs(16'd10486, 16'd5243, 16'd1966, 16'd4063, 16'd16384);
        random_phase(35, 1);
        drain();

        if (tracker.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
